// File: rtl/qalu_pkg.sv
// Package for the quaternion Q16.16 ALU: payload structs, action codes,
// term tables and saturating arithmetic helpers. No dependencies.
package qalu_pkg;

  localparam logic [2:0] ACT_PRODUCT = 3'd0;
  localparam logic [2:0] ACT_ADD     = 3'd1;
  localparam logic [2:0] ACT_SUB     = 3'd2;
  localparam logic [2:0] ACT_DOT     = 3'd3;
  localparam logic [2:0] ACT_CONJ    = 3'd4;
  localparam logic [2:0] ACT_NEG     = 3'd5;
  localparam logic [2:0] ACT_SCALE   = 3'd6;
  localparam logic [2:0] ACT_HEMI    = 3'd7;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef logic [31:0]            q_t;
  typedef logic [3:0][31:0]       quat_t;
  typedef logic [3:0][63:0]       wquat_t;
  typedef logic [3:0][3:0][63:0]  prod_t;
  typedef logic [4:0][3:0][31:0]  terms_t;
  typedef logic [4:0][31:0]       sums_t;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] dot_value;
    logic               flipped;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] action;
  } ctrl_t;

  typedef struct packed {
    quat_t simple;
    quat_t neg_a;
    quat_t a;
  } side_t;

  // Sum rows: r_w, r_x, r_y, r_z, dot. Step k uses a[k] times b[TERM_B[row][k]].
  localparam logic [4:0][3:0][1:0] TERM_B = '{
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // Set bit k: step k subtracts its term.
  localparam logic [4:0][3:0] TERM_NEG = '{4'b0000, 4'b0100, 4'b0010, 4'b1000, 4'b1110};

  function automatic q_t sat33(input logic [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? Q_MIN : Q_MAX;
    end
    return v[31:0];
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  function automatic q_t qneg(input q_t a);
    return sat33(33'd0 - {a[31], a});
  endfunction

  function automatic q_t qstep(input q_t acc, input q_t t, input logic sub);
    return sub ? qsub(acc, t) : qadd(acc, t);
  endfunction

  // Round to nearest (ties up), drop 16 fraction bits, saturate.
  function automatic q_t qround(input logic [63:0] p);
    logic [63:0] r;
    r = p + 64'd32768;
    if (r[63:47] != {17{r[63]}}) begin
      return r[63] ? Q_MIN : Q_MAX;
    end
    return r[47:16];
  endfunction

endpackage

// File: rtl/quaternion_fixed_point_alu.sv
// Quaternion Q16.16 ALU, top level. Depends on qalu_pkg, qalu_mul, qalu_round, qalu_sum.
// An accepted item passes the multiply, round, two accumulate and output registers before out_valid rises.
// Throughput: one item per cycle; busy stays low, every stage advances each cycle.
// Stages: multiply, round, two accumulate steps, last accumulate step with result select.
// Reset: synchronous active-low rst_n clears all valid bits; no item survives reset.
module quaternion_fixed_point_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qalu_pkg::in_item_t  in_data,
  output logic                out_valid,
  output qalu_pkg::out_item_t out_data
);
  import qalu_pkg::*;

  logic   in_valid;
  ctrl_t  mul_ctrl;
  prod_t  mul_prod;
  wquat_t mul_scl;
  quat_t  mul_a;
  quat_t  mul_b;
  ctrl_t  rnd_ctrl;
  terms_t rnd_terms;
  side_t  rnd_side;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  qalu_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .item_i  (in_data),
    .ctrl_o  (mul_ctrl),
    .prod_o  (mul_prod),
    .scl_o   (mul_scl),
    .a_o     (mul_a),
    .b_o     (mul_b)
  );

  qalu_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (mul_ctrl),
    .prod_i (mul_prod),
    .scl_i  (mul_scl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctrl_o (rnd_ctrl),
    .terms_o(rnd_terms),
    .side_o (rnd_side)
  );

  qalu_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (rnd_ctrl),
    .terms_i  (rnd_terms),
    .side_i   (rnd_side),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// File: rtl/qalu_mul.sv
// Multiplier stage: all sixteen a*b cross products and four a*scalar products.
// Depends on qalu_pkg.
module qalu_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  qalu_pkg::in_item_t item_i,
  output qalu_pkg::ctrl_t    ctrl_o,
  output qalu_pkg::prod_t    prod_o,
  output qalu_pkg::wquat_t   scl_o,
  output qalu_pkg::quat_t    a_o,
  output qalu_pkg::quat_t    b_o
);
  import qalu_pkg::*;

  quat_t  a_in;
  quat_t  b_in;
  prod_t  prod_nxt;
  wquat_t scl_nxt;

  logic       valid_r;
  logic [2:0] action_r;
  prod_t      prod_r;
  wquat_t     scl_r;
  quat_t      a_r;
  quat_t      b_r;

  assign a_in = {item_i.a_z, item_i.a_y, item_i.a_x, item_i.a_w};
  assign b_in = {item_i.b_z, item_i.b_y, item_i.b_x, item_i.b_w};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = $signed(a_in[i]) * $signed(b_in[j]);
      end
      scl_nxt[i] = $signed(a_in[i]) * $signed(item_i.scalar);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= item_i.action;
    prod_r   <= prod_nxt;
    scl_r    <= scl_nxt;
    a_r      <= a_in;
    b_r      <= b_in;
  end

  assign ctrl_o = '{valid: valid_r, action: action_r};
  assign prod_o = prod_r;
  assign scl_o  = scl_r;
  assign a_o    = a_r;
  assign b_o    = b_r;

endmodule

// File: rtl/qalu_round.sv
// Rounding stage: rounds and saturates products, sorts them into sum terms
// and forms the results of the element-wise actions. Depends on qalu_pkg.
module qalu_round (
  input  logic              clk,
  input  logic              rst_n,
  input  qalu_pkg::ctrl_t   ctrl_i,
  input  qalu_pkg::prod_t   prod_i,
  input  qalu_pkg::wquat_t  scl_i,
  input  qalu_pkg::quat_t   a_i,
  input  qalu_pkg::quat_t   b_i,
  output qalu_pkg::ctrl_t   ctrl_o,
  output qalu_pkg::terms_t  terms_o,
  output qalu_pkg::side_t   side_o
);
  import qalu_pkg::*;

  logic [3:0][3:0][31:0] qm;
  quat_t  qs;
  quat_t  neg_a;
  quat_t  simple;
  terms_t terms_nxt;

  logic       valid_r;
  logic [2:0] action_r;
  terms_t     terms_r;
  side_t      side_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        qm[i][j] = qround(prod_i[i][j]);
      end
      qs[i]    = qround(scl_i[i]);
      neg_a[i] = qneg(a_i[i]);
    end
    for (int c = 0; c < 5; c++) begin
      for (int k = 0; k < 4; k++) begin
        terms_nxt[c][k] = qm[k][TERM_B[c][k]];
      end
    end
  end

  always_comb begin
    simple = '0;
    unique case (ctrl_i.action)
      ACT_ADD: begin
        for (int i = 0; i < 4; i++) simple[i] = qadd(a_i[i], b_i[i]);
      end
      ACT_SUB: begin
        for (int i = 0; i < 4; i++) simple[i] = qsub(a_i[i], b_i[i]);
      end
      ACT_CONJ: begin
        simple    = neg_a;
        simple[0] = a_i[0];
      end
      ACT_NEG: begin
        simple = neg_a;
      end
      ACT_SCALE: begin
        simple = qs;
      end
      default: begin
        simple = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= ctrl_i.action;
    terms_r  <= terms_nxt;
    side_r   <= '{simple: simple, neg_a: neg_a, a: a_i};
  end

  assign ctrl_o  = '{valid: valid_r, action: action_r};
  assign terms_o = terms_r;
  assign side_o  = side_r;

endmodule

// File: rtl/qalu_sum.sv
// Accumulate stages: three saturating add/subtract steps per sum, then the
// final result select into the output register. Depends on qalu_pkg.
module qalu_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  qalu_pkg::ctrl_t     ctrl_i,
  input  qalu_pkg::terms_t    terms_i,
  input  qalu_pkg::side_t     side_i,
  output logic                out_valid,
  output qalu_pkg::out_item_t out_data
);
  import qalu_pkg::*;

  sums_t     acc1_nxt;
  sums_t     acc2_nxt;
  sums_t     fin;
  quat_t     rq;
  logic      hemi_neg;
  out_item_t out_nxt;

  logic                  s3_valid_r;
  logic [2:0]            s3_action_r;
  sums_t                 s3_acc_r;
  logic [4:0][1:0][31:0] s3_tail_r;
  side_t                 s3_side_r;

  logic       s4_valid_r;
  logic [2:0] s4_action_r;
  sums_t      s4_acc_r;
  sums_t      s4_last_r;
  side_t      s4_side_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  always_comb begin
    for (int c = 0; c < 5; c++) begin
      acc1_nxt[c] = qstep(terms_i[c][0], terms_i[c][1], TERM_NEG[c][1]);
      acc2_nxt[c] = qstep(s3_acc_r[c], s3_tail_r[c][0], TERM_NEG[c][2]);
      fin[c]      = qstep(s4_acc_r[c], s4_last_r[c], TERM_NEG[c][3]);
    end
  end

  assign hemi_neg = fin[4][31];

  always_comb begin
    rq              = s4_side_r.simple;
    out_nxt.flipped = 1'b0;
    unique case (s4_action_r)
      ACT_PRODUCT: begin
        rq = fin[3:0];
      end
      ACT_DOT: begin
        rq = '0;
      end
      ACT_HEMI: begin
        rq              = hemi_neg ? s4_side_r.neg_a : s4_side_r.a;
        out_nxt.flipped = hemi_neg;
      end
      default: begin
        rq = s4_side_r.simple;
      end
    endcase
    out_nxt.r_w       = rq[0];
    out_nxt.r_x       = rq[1];
    out_nxt.r_y       = rq[2];
    out_nxt.r_z       = rq[3];
    out_nxt.dot_value = fin[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= ctrl_i.valid;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_action_r <= ctrl_i.action;
    s3_acc_r    <= acc1_nxt;
    for (int c = 0; c < 5; c++) begin
      s3_tail_r[c] <= terms_i[c][3:2];
      s4_last_r[c] <= s3_tail_r[c][1];
    end
    s3_side_r   <= side_i;
    s4_action_r <= s3_action_r;
    s4_acc_r    <= acc2_nxt;
    s4_side_r   <= s3_side_r;
    out_data_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flip_neg_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.flipped) |-> out_data_r.dot_value[31])
    else $error("flipped result with non-negative dot product");

  a_dot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && s4_action_r == ACT_DOT) |=>
    (out_valid_r && out_data_r.r_w == '0 && out_data_r.r_x == '0 &&
     out_data_r.r_y == '0 && out_data_r.r_z == '0 && !out_data_r.flipped))
    else $error("dot action left a nonzero quaternion");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |=> out_valid_r)
    else $error("item dropped at output stage");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result strobe after reset");

endmodule
